// ----- hdl/kf_pkg.sv -----
package kf_pkg;

    // default generics of the top level
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // fixed field widths
    localparam int ERR_W = 32;   // P, R and Q, unsigned fixed point
    localparam int EST_W = 32;   // estimate, signed fixed point
    localparam int RES_W = 33;   // residual, signed fixed point

    // apb register file
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_MEAS_NOISE    = 2'd0;
    localparam logic [1:0] REG_INIT_EST_ERR  = 2'd1;
    localparam logic [1:0] REG_PROCESS_NOISE = 2'd2;

    localparam logic [ERR_W-1:0] MEAS_NOISE_RST    = 32'd131072;
    localparam logic [ERR_W-1:0] INIT_EST_ERR_RST  = 32'd131072;
    localparam logic [ERR_W-1:0] PROCESS_NOISE_RST = 32'd65536;

    // multiplier digit size, bits of the multiplier consumed per cycle
    localparam int DIGIT_W = 8;

    typedef enum logic [1:0] {
        MUL_GAIN,
        MUL_KEEP,
        MUL_NOISE
    } kf_mul_sel_t;

    typedef struct packed {
        logic        capture;
        logic        div_start;
        logic        mul_start;
        kf_mul_sel_t mul_sel;
        logic        upd_est;
        logic        calc_abs;
        logic        latch_keep;
        logic        upd_err;
        logic        load_out;
    } kf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
    } kf_sts_t;

endpackage

// ----- hdl/scalar_kalman_filter.sv -----
// scalar kalman filter on a stream of signed integer samples
// input channel: sample with in_valid / in_stall, a beat moves when in_valid
//   is high and in_stall is low at a rising edge of clk
// output channel: estimate, residual and gain with out_valid / out_stall, one
//   result beat for every input beat, in order
// config: apb-style port, meas_noise at 0x0, init_est_err at 0x4,
//   process_noise at 0x8; writing init_est_err also reloads the error P;
//   write only while the filter is idle
// timing: a sample takes FRAC_BITS + 27 cycles from acceptance to
//   out_valid (43 at the default), and a new sample is taken one cycle after
//   the result is loaded, so FRAC_BITS + 28 cycles per item (44); the
//   restoring divider for the gain (one quotient bit per cycle) and three
//   products on the shared 8-bit-digit multiplier set that figure
// stall: a finished result waits in the output register while out_stall is
//   high, and the next sample can already be accepted and processed; it then
//   waits in the last state until the output register frees up
// reset: rst_n is asynchronous, active low; registers return to their reset
//   values, P takes the init_est_err reset value, the estimate clears to zero
module scalar_kalman_filter
    import kf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // sample input
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           in_valid,
    output logic                           in_stall,

    // filtered output
    output logic signed [EST_W-1:0]        estimate,
    output logic signed [RES_W-1:0]        residual,
    output logic        [FRAC_BITS:0]      gain,
    output logic                           out_valid,
    input  logic                           out_stall,

    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [CFG_ADDR_W-1:0]   paddr,
    input  logic        [CFG_DATA_W-1:0]   pwdata,
    output logic        [CFG_DATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [ERR_W-1:0] meas_noise_reg;
    logic [ERR_W-1:0] init_est_err_reg;
    logic [ERR_W-1:0] process_noise_reg;

    logic    wr_en;
    logic    p_load;
    kf_cmd_t cmd;
    kf_sts_t sts;

    // zero wait state port, write lands in the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign p_load = wr_en && (paddr[3:2] == REG_INIT_EST_ERR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_noise_reg    <= MEAS_NOISE_RST;
            init_est_err_reg  <= INIT_EST_ERR_RST;
            process_noise_reg <= PROCESS_NOISE_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MEAS_NOISE:    meas_noise_reg    <= pwdata;
                REG_INIT_EST_ERR:  init_est_err_reg  <= pwdata;
                REG_PROCESS_NOISE: process_noise_reg <= pwdata;
                default:           ;  // unmapped slot, write ignored
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_MEAS_NOISE:    prdata = meas_noise_reg;
            REG_INIT_EST_ERR:  prdata = init_est_err_reg;
            REG_PROCESS_NOISE: prdata = process_noise_reg;
            default:           prdata = '0;
        endcase
    end

    // sequencer: walks one sample through divide, multiply and update steps
    kf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic, filter state and output register
    kf_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample),
        .meas_noise    (meas_noise_reg),
        .process_noise (process_noise_reg),
        .p_load        (p_load),
        .p_load_value  (pwdata),
        .estimate      (estimate),
        .residual      (residual),
        .gain          (gain)
    );

endmodule

// ----- hdl/kf_div.sv -----
module kf_div
    import kf_pkg::*;
#(
    parameter int QW = FRAC_BITS_DEF + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ERR_W-1:0] num,
    input  logic [ERR_W:0]   den,
    output logic             done,
    output logic [QW-1:0]    quot
);

    localparam int CNT_W = $clog2(QW);

    logic [ERR_W:0]   rem_reg;
    logic [ERR_W:0]   den_reg;
    logic [QW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             first_reg;
    logic             zero_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [ERR_W+1:0] cand;
    logic [ERR_W+1:0] cand_diff;
    logic             cand_ge;
    logic [ERR_W:0]   rem_next;

    // first step compares the bare numerator, later steps the shifted remainder
    assign cand      = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign cand_ge   = cand >= {1'b0, den_reg};
    assign cand_diff = cand - {1'b0, den_reg};
    assign rem_next  = cand_ge ? cand_diff[ERR_W:0] : cand[ERR_W:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= {1'b0, num};
            den_reg   <= den;
            q_reg     <= '0;
            first_reg <= 1'b1;
            zero_reg  <= (den == '0);
            cnt_reg   <= CNT_W'(QW - 1);
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            q_reg     <= {q_reg[QW-2:0], cand_ge};
            first_reg <= 1'b0;
            cnt_reg   <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : q_reg;

endmodule

// ----- hdl/kf_mul.sv -----
module kf_mul
    import kf_pkg::*;
#(
    parameter int MCW = 33,
    parameter int MLW = 33
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [MCW-1:0]      mcand,
    input  logic        [MLW-1:0]      mplier,
    output logic                       done,
    output logic signed [MCW+MLW-1:0]  product
);

    localparam int PW     = MCW + MLW;
    localparam int NDIG   = (MLW + DIGIT_W - 1) / DIGIT_W;
    localparam int ML_PAD = NDIG * DIGIT_W;
    localparam int CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic signed [PW-1:0]  acc_reg;
    logic signed [PW-1:0]  mc_reg;
    logic [ML_PAD-1:0]     ml_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic signed [PW-1:0]  dig_ext;
    logic signed [PW-1:0]  pp;

    // one multiplier digit times the shifted multiplicand per cycle
    assign dig_ext = PW'($signed({1'b0, ml_reg[DIGIT_W-1:0]}));
    assign pp      = mc_reg * dig_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= PW'(mcand);
            ml_reg  <= ML_PAD'(mplier);
            cnt_reg <= CNT_W'(NDIG - 1);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp;
            mc_reg  <= mc_reg <<< DIGIT_W;
            ml_reg  <= ml_reg >> DIGIT_W;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hdl/kf_dp.sv -----
module kf_dp
    import kf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kf_cmd_t                        cmd,
    output kf_sts_t                        sts,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [ERR_W-1:0]        meas_noise,
    input  logic        [ERR_W-1:0]        process_noise,
    input  logic                           p_load,
    input  logic        [ERR_W-1:0]        p_load_value,
    output logic signed [EST_W-1:0]        estimate,
    output logic signed [RES_W-1:0]        residual,
    output logic        [FRAC_BITS:0]      gain
);

    localparam int GW    = FRAC_BITS + 1;
    localparam int ZW    = SAMPLE_WIDTH + FRAC_BITS;
    localparam int DW    = ((ZW > EST_W) ? ZW : EST_W) + 1;
    localparam int AW    = EST_W + 1;
    localparam int MCW   = DW;
    localparam int MLW   = (GW > AW) ? GW : AW;
    localparam int PW    = MCW + MLW;
    localparam int SUM_W = PW - FRAC_BITS + 1;

    localparam logic [GW-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PW-1:0] EST_MAX = {{(PW-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}};
    localparam logic signed [PW-1:0] EST_MIN = {{(PW-EST_W+1){1'b1}}, {(EST_W-1){1'b0}}};
    localparam logic signed [DW-1:0] RES_MAX = {{(DW-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic signed [DW-1:0] RES_MIN = {{(DW-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic        [ERR_W-1:0]        p_reg;
    logic signed [EST_W-1:0]        old_reg;
    logic signed [EST_W-1:0]        nxt_reg;
    logic        [AW-1:0]           a_reg;
    logic        [ERR_W-1:0]        keep_reg;
    logic signed [EST_W-1:0]        estimate_reg;
    logic signed [RES_W-1:0]        residual_reg;
    logic        [GW-1:0]           gain_reg;

    logic signed [ZW-1:0]     zfx;
    logic signed [DW-1:0]     zfx_ext;
    logic signed [DW-1:0]     diff;
    logic        [ERR_W:0]    den;
    logic        [GW-1:0]     gain_q;
    logic        [GW-1:0]     keep_fac;
    logic signed [MCW-1:0]    mcand;
    logic        [MLW-1:0]    mplier;
    logic signed [PW-1:0]     product;
    logic signed [PW-1:0]     delta;
    logic signed [PW-1:0]     est_sum;
    logic signed [EST_W-1:0]  nxt_sat;
    logic signed [AW-1:0]     d;
    logic        [AW-1:0]     a_val;
    logic        [SUM_W-1:0]  err_sum;
    logic        [ERR_W-1:0]  p_sat;
    logic signed [DW-1:0]     rdiff;
    logic signed [RES_W-1:0]  res_sat;

    // sample scaled into the fixed-point grid
    assign zfx     = {sample_reg, {FRAC_BITS{1'b0}}};
    assign zfx_ext = DW'(zfx);
    assign diff    = zfx_ext - DW'(old_reg);
    assign den     = {1'b0, p_reg} + {1'b0, meas_noise};

    kf_div #(
        .QW (GW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (p_reg),
        .den   (den),
        .done  (sts.div_done),
        .quot  (gain_q)
    );

    assign keep_fac = ONE_FX - gain_q;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_GAIN:
            begin
                mcand  = diff;
                mplier = MLW'(gain_q);
            end
            MUL_KEEP:
            begin
                mcand  = MCW'($signed({1'b0, p_reg}));
                mplier = MLW'(keep_fac);
            end
            MUL_NOISE:
            begin
                mcand  = MCW'($signed({1'b0, process_noise}));
                mplier = MLW'(a_reg);
            end
            default:
            begin
                mcand  = '0;
                mplier = '0;
            end
        endcase
    end

    kf_mul #(
        .MCW (MCW),
        .MLW (MLW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .mcand   (mcand),
        .mplier  (mplier),
        .done    (sts.mul_done),
        .product (product)
    );

    // estimate step, floored shift then saturation
    assign delta   = product >>> FRAC_BITS;
    assign est_sum = delta + PW'(old_reg);

    always_comb
    begin
        if (est_sum > EST_MAX)
            nxt_sat = EST_MAX[EST_W-1:0];
        else if (est_sum < EST_MIN)
            nxt_sat = EST_MIN[EST_W-1:0];
        else
            nxt_sat = est_sum[EST_W-1:0];
    end

    // distance moved by the estimate
    assign d     = AW'(old_reg) - AW'(nxt_reg);
    assign a_val = d[AW-1] ? AW'(-d) : AW'(d);

    // error update, saturating at all ones
    assign err_sum = SUM_W'(keep_reg) + SUM_W'(product[PW-1:FRAC_BITS]);
    assign p_sat   = (|err_sum[SUM_W-1:ERR_W]) ? '1 : err_sum[ERR_W-1:0];

    assign rdiff = zfx_ext - DW'(nxt_reg);

    always_comb
    begin
        if (rdiff > RES_MAX)
            res_sat = RES_MAX[RES_W-1:0];
        else if (rdiff < RES_MIN)
            res_sat = RES_MIN[RES_W-1:0];
        else
            res_sat = rdiff[RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg   <= INIT_EST_ERR_RST;
            old_reg <= '0;
        end
        else if (p_load)
        begin
            p_reg <= p_load_value;
        end
        else if (cmd.upd_err)
        begin
            p_reg   <= p_sat;
            old_reg <= nxt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sample_reg <= sample;
        if (cmd.upd_est)
            nxt_reg <= nxt_sat;
        if (cmd.calc_abs)
            a_reg <= a_val;
        if (cmd.latch_keep)
            keep_reg <= product[FRAC_BITS+ERR_W-1:FRAC_BITS];
        if (cmd.load_out)
        begin
            estimate_reg <= nxt_reg;
            residual_reg <= res_sat;
            gain_reg     <= gain_q;
        end
    end

    assign estimate = estimate_reg;
    assign residual = residual_reg;
    assign gain     = gain_reg;

endmodule

// ----- hdl/kf_ctrl.sv -----
module kf_ctrl
    import kf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  kf_sts_t sts,
    output kf_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV,
        S_MUL1_GO,
        S_MUL1,
        S_EST,
        S_MUL2_GO,
        S_MUL2,
        S_MUL3_GO,
        S_MUL3,
        S_ERR,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_MUL1_GO;
            end
            S_MUL1_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_GAIN;
                state_next    = S_MUL1;
            end
            S_MUL1:
            begin
                if (sts.mul_done)
                    state_next = S_EST;
            end
            S_EST:
            begin
                cmd.upd_est = 1'b1;
                state_next  = S_MUL2_GO;
            end
            S_MUL2_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_KEEP;
                cmd.calc_abs  = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                if (sts.mul_done)
                    state_next = S_MUL3_GO;
            end
            S_MUL3_GO:
            begin
                cmd.latch_keep = 1'b1;
                cmd.mul_start  = 1'b1;
                cmd.mul_sel    = MUL_NOISE;
                state_next     = S_MUL3;
            end
            S_MUL3:
            begin
                if (sts.mul_done)
                    state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.upd_err = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/kf_chk.sv -----
module kf_chk
#(
    parameter int FRAC_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic signed [31:0]    estimate,
    input logic signed [32:0]    residual,
    input logic [FRAC_BITS:0]    gain
);

    localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(estimate) && $stable(residual) && $stable(gain))
        else $error("result payload changed while stalled");

    // one sample at a time: the input closes right after a beat is taken
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while one is in flight");

    // the gain never exceeds one
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain <= GAIN_ONE)
        else $error("gain above one");

endmodule

bind scalar_kalman_filter kf_chk #(.FRAC_BITS(FRAC_BITS)) u_kf_chk (.*);

// ----- sim/kf_checker.sv -----
`timescale 1ns / 1ps
module kf_checker
    import kf_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
    input  logic                               in_valid,
    input  logic                               in_stall,

    input  logic signed [EST_W-1:0]            estimate,
    input  logic signed [RES_W-1:0]            residual,
    input  logic        [FRAC_BITS_DEF:0]      gain,
    input  logic                               out_valid,
    input  logic                               out_stall,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic        [CFG_ADDR_W-1:0]       paddr,
    input  logic        [CFG_DATA_W-1:0]       pwdata,
    input  logic        [CFG_DATA_W-1:0]       prdata,
    input  logic                               pready,

    output int                                 fail_count,
    output int                                 pending,
    output int                                 n_checked
);

    localparam int FB = FRAC_BITS_DEF;
    localparam int PRINT_CAP = 50;

    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;
    localparam longint RES_MAX = 64'sd4294967295;
    localparam longint RES_MIN = -64'sd4294967296;

    localparam logic [95:0] ONE_W  = 96'd1 << FB;
    localparam logic [95:0] SAT_P  = 96'hFFFF_FFFF;

    typedef struct packed {
        logic signed [EST_W-1:0] est;
        logic signed [RES_W-1:0] res;
        logic        [FB:0]      gain;
    } filt_beat_t;

    // register copies and filter state
    logic        [ERR_W-1:0] r_noise;
    logic        [ERR_W-1:0] p_init;
    logic        [ERR_W-1:0] q_noise;
    logic signed [EST_W-1:0] est_x;
    logic        [ERR_W-1:0] err_p;

    filt_beat_t expected_beats[$];

    function automatic filt_beat_t kalman_update(input logic signed [SAMPLE_WIDTH_DEF-1:0] z);
        filt_beat_t  r;
        longint      zfx;
        longint      old;
        longint      prod;
        longint      nxt;
        longint      d;
        longint      res;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] g;
        logic [63:0] mag;
        logic [95:0] keep;
        logic [95:0] noise;
        logic [95:0] newp;

        zfx = longint'(z) <<< FB;

        // gain = P / (P + R), zero when the sum is zero
        den = 64'(err_p) + 64'(r_noise);
        num = 64'(err_p) << FB;
        g   = (den == 64'd0) ? 64'd0 : num / den;

        // estimate step, floor of the product, saturated to 32 bits
        old  = longint'(est_x);
        prod = longint'(g) * (zfx - old);
        nxt  = old + (prod >>> FB);
        if (nxt > EST_MAX)
            nxt = EST_MAX;
        else if (nxt < EST_MIN)
            nxt = EST_MIN;

        // error update, saturating at all ones
        keep  = ((ONE_W - 96'(g)) * 96'(err_p)) >> FB;
        d     = old - nxt;
        mag   = (d < 0) ? -d : d;
        noise = (96'(mag) * 96'(q_noise)) >> FB;
        newp  = keep + noise;
        if (newp > SAT_P)
            newp = SAT_P;

        res = zfx - nxt;
        if (res > RES_MAX)
            res = RES_MAX;
        else if (res < RES_MIN)
            res = RES_MIN;

        err_p  = newp[ERR_W-1:0];
        est_x  = nxt[EST_W-1:0];
        r.est  = nxt[EST_W-1:0];
        r.res  = res[RES_W-1:0];
        r.gain = g[FB:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
        else if (fail_count == PRINT_CAP)
            $display("%0t: further mismatches are counted silently", $time);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        filt_beat_t want;
        logic [ERR_W-1:0] reg_val;

        if (!rst_n) begin
            r_noise = MEAS_NOISE_RST;
            p_init  = INIT_EST_ERR_RST;
            q_noise = PROCESS_NOISE_RST;
            est_x   = '0;
            err_p   = INIT_EST_ERR_RST;
            expected_beats.delete();
            pending   <= 0;
            n_checked <= 0;
        end else begin
            // result beat against the oldest expectation
            if (out_valid && !out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected result, estimate", 64'(estimate), 64'd0);
                end else begin
                    want = expected_beats.pop_front();
                    if (estimate !== want.est)
                        report_mismatch("estimate", 64'(estimate), 64'(want.est));
                    if (residual !== want.res)
                        report_mismatch("residual", 64'(residual), 64'(want.res));
                    if (gain !== want.gain)
                        report_mismatch("gain", 64'(gain), 64'(want.gain));
                    n_checked <= n_checked + 1;
                end
            end

            if (in_valid && !in_stall)
                expected_beats.push_back(kalman_update(sample));

            // register port, access phase
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_MEAS_NOISE:    r_noise = pwdata;
                        REG_INIT_EST_ERR:
                        begin
                            p_init = pwdata;
                            err_p  = pwdata;
                        end
                        REG_PROCESS_NOISE: q_noise = pwdata;
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        REG_MEAS_NOISE:    reg_val = r_noise;
                        REG_INIT_EST_ERR:  reg_val = p_init;
                        REG_PROCESS_NOISE: reg_val = q_noise;
                        default:           reg_val = prdata;
                    endcase
                    if (prdata !== reg_val)
                        report_mismatch("register read", 64'(prdata), 64'(reg_val));
                end
            end

            pending <= expected_beats.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import kf_pkg::*;

    localparam int IDLE_LIMIT  = 3000;  // cycles with no beat on any port
    localparam int TAIL_CYCLES = 120;
    localparam int N_PHASES    = 8;

    // a write here must be ignored by the block
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } stall_mode_t;

    typedef enum logic [2:0] {
        SEQ_NOISY_LEVEL,
        SEQ_RAMP,
        SEQ_STEPS,
        SEQ_RANDOM,
        SEQ_EXTREMES
    } seq_kind_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;

    logic signed [SAMPLE_WIDTH_DEF-1:0] sample = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;

    logic signed [EST_W-1:0]            estimate;
    logic signed [RES_W-1:0]            residual;
    logic        [FRAC_BITS_DEF:0]      gain;
    logic                               out_valid;
    logic                               out_stall = 1'b0;

    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic        [CFG_ADDR_W-1:0]       paddr = '0;
    logic        [CFG_DATA_W-1:0]       pwdata = '0;
    logic        [CFG_DATA_W-1:0]       prdata;
    logic                               pready;

    int fail_count;
    int pending;
    int n_checked;

    int n_sent     = 0;
    int n_settings = 0;
    int burst_left = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    scalar_kalman_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .estimate  (estimate),
        .residual  (residual),
        .gain      (gain),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predicts every result beat and compares it, also checks register reads
    kf_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .estimate   (estimate),
        .residual   (residual),
        .gain       (gain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .n_checked  (n_checked)
    );

    // receiver back-pressure: a mode is kept for a random stretch, from no
    // stall at all up to long blocks that keep a finished result waiting
    // while the next sample is already being filtered
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= ((stall_left % 64) < 40);
        endcase
    end

    // watchdog: ends the run when no beat moves for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("scalar_kalman_filter regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample beat; the sender works in bursts with random gaps, a gap of
    // zero now and then gives back-to-back stretches
    task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        sample   <= s;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        n_sent++;
    endtask

    // drop valid and wait until every predicted result beat has been seen
    task automatic wait_idle;
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // apb access: setup phase, access phase until pready, then back to idle
    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [CFG_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write R, P and Q, then read all three back; only called while idle
    task automatic apply_config(input logic [ERR_W-1:0] r, input logic [ERR_W-1:0] p,
                                input logic [ERR_W-1:0] q);
        apb_access(REG_MEAS_NOISE, 1'b1, r);
        apb_access(REG_INIT_EST_ERR, 1'b1, p);
        apb_access(REG_PROCESS_NOISE, 1'b1, q);
        apb_access(REG_MEAS_NOISE, 1'b0, '0);
        apb_access(REG_INIT_EST_ERR, 1'b0, '0);
        apb_access(REG_PROCESS_NOISE, 1'b0, '0);
        n_settings++;
    endtask

    // random part of one setting: segments of sensor-like sequences (a level
    // with noise, ramps, level steps) with some raw random and rail-to-rail
    // segments mixed in
    task automatic run_phase(input int n_items);
        int        left;
        int        seg;
        int        amp;
        int        level;
        int        step;
        int        v;
        int        pick;
        seq_kind_t kind;

        left = n_items;
        while (left > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                kind = SEQ_NOISY_LEVEL;
            else if (pick < 6)
                kind = SEQ_RAMP;
            else if (pick < 8)
                kind = SEQ_STEPS;
            else if (pick == 8)
                kind = SEQ_RANDOM;
            else
                kind = SEQ_EXTREMES;

            seg   = $urandom_range(8, 40);
            if (seg > left)
                seg = left;
            level = int'($urandom_range(0, 65535)) - 32768;
            amp   = 1 << $urandom_range(0, 12);
            step  = int'($urandom_range(0, 2048)) - 1024;

            repeat (seg)
            begin
                case (kind)
                    SEQ_NOISY_LEVEL: v = level + int'($urandom_range(0, 2 * amp)) - amp;
                    SEQ_RAMP:
                    begin
                        level = level + step;
                        v     = level;
                    end
                    SEQ_STEPS:
                    begin
                        if ($urandom_range(0, 7) == 0)
                            level = int'($urandom_range(0, 65535)) - 32768;
                        v = level + int'($urandom_range(0, 16)) - 8;
                    end
                    SEQ_RANDOM:      v = int'($urandom_range(0, 65535)) - 32768;
                    default:         v = $urandom_range(0, 1) ? 32767 : -32768;
                endcase
                // keep the sample inside the 16-bit range
                if (v > 32767)
                    v = 32767;
                else if (v < -32768)
                    v = -32768;
                send_sample(v[SAMPLE_WIDTH_DEF-1:0]);
            end
            left -= seg;
        end
    endtask

    initial
    begin
        logic [ERR_W-1:0] r;
        logic [ERR_W-1:0] p;
        logic [ERR_W-1:0] q;

        // hold reset, then release it at a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers: rails, unit steps, alternating bits
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        wait_idle();

        // no measurement noise: the gain is exactly one
        apply_config(32'd0, 32'h0002_0000, 32'h0001_0000);
        send_sample(16'sd100);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        wait_idle();

        // P and R both zero: zero denominator, the gain stays at zero
        apply_config(32'd0, 32'd0, 32'h0001_0000);
        send_sample(16'sd5);
        send_sample(-16'sd5);
        wait_idle();

        // everything at full scale: the error update saturates
        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        wait_idle();

        // smallest nonzero noise, no process noise
        apply_config(32'd1, 32'd1, 32'd0);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        wait_idle();

        // the unused register slot must not disturb the filter
        apb_access(REG_UNUSED, 1'b1, $urandom);
        send_sample(16'sd7);
        wait_idle();

        // random part, one register setting per phase, extremes included
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    r = 32'h0001_0000;
                    p = 32'h0010_0000;
                    q = 32'h0000_0100;
                end
                1:
                begin
                    r = 32'd0;
                    p = $urandom;
                    q = $urandom_range(0, 32'hFFFF);
                end
                2:
                begin
                    r = 32'hFFFF_FFFF;
                    p = 32'hFFFF_FFFF;
                    q = 32'hFFFF_FFFF;
                end
                3:
                begin
                    r = $urandom;
                    p = 32'd0;
                    q = 32'd0;
                end
                4:
                begin
                    r = $urandom;
                    p = $urandom;
                    q = $urandom;
                end
                5:
                begin
                    r = $urandom_range(1 << 12, 1 << 20);
                    p = $urandom_range(0, 1 << 24);
                    q = $urandom_range(0, 1 << 10);
                end
                6:
                begin
                    r = 32'd1;
                    p = 32'hFFFF_FFFF;
                    q = 32'd1;
                end
                default:
                begin
                    r = $urandom;
                    p = $urandom;
                    q = 32'd0;
                end
            endcase
            apply_config(r, p, q);
            run_phase($urandom_range(140, 170));
            wait_idle();
        end

        // let any stray result beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d samples under %0d register settings, %0d results checked",
                 n_sent, n_settings, n_checked);
        $display("%0d mismatches", fail_count);
        if (fail_count == 0)
            $display("scalar_kalman_filter regression: pass");
        else
            $display("scalar_kalman_filter regression: fail");
        $finish;
    end

endmodule

// ----- scalar_kalman_filter.f -----
hdl/kf_pkg.sv
hdl/kf_div.sv
hdl/kf_mul.sv
hdl/kf_dp.sv
hdl/kf_ctrl.sv
hdl/scalar_kalman_filter.sv
hdl/kf_chk.sv
sim/kf_checker.sv
sim/tb.sv
